FILE: design/mera_pkg.sv
package mera_pkg;

    localparam int MAX_N_DEF   = 64;
    localparam int GRID_W      = 7;
    localparam int AREA_W      = 13;
    localparam int GRID_RESET  = 64;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_hgt_ctl;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

endpackage

FILE: design/max_empty_rectangle_area_unit.sv
// Each cell transfer passes an accept cycle, then stack steps that pop one entry each, and a
// last stack step that pushes the new column height.
// At each row end a flush pops the remaining stack entries while the height ring
// rotates back into place.
// The area leaves through an output register in the cycle after the last flush step of the last row.
// Reset clears heights, counts, stack depth and best area and sets the grid size to 64.
module max_empty_rectangle_area_unit #(
    parameter int MAX_N = mera_pkg::MAX_N_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mera_pkg::GRID_W-1:0]         i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Bit 0: cell_req. Bits 7:1: zero.
    input  logic [mera_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Bits 12:0: max_area. Bits 15:13: zero.
    output logic [mera_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int W  = $clog2(MAX_N + 1);
    localparam int AW = mera_pkg::AREA_W;
    localparam int OW = mera_pkg::OUT_TDATA_W;
    localparam int GW = mera_pkg::GRID_W;

    localparam logic [1:0] S_RUN   = 2'd0;
    localparam logic [1:0] S_POP   = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]      r_state, n_state;
    logic [GW-1:0]   r_grid;
    logic [W-1:0]    r_col, n_col;
    logic [W-1:0]    r_row, n_row;
    logic [W-1:0]    r_depth, n_depth;
    logic [W-1:0]    r_cur_h, n_cur_h;
    logic [W-1:0]    r_cur_i, n_cur_i;
    logic [W-1:0]    r_rot, n_rot;
    logic [2*W-1:0]  r_best, n_best;
    logic            r_ovalid, n_ovalid;
    logic [AW-1:0]   r_odata, n_odata;

    logic [W-1:0]    w_n;
    logic [W-1:0]    w_hq [MAX_N];
    logic [W-1:0]    w_head;
    logic [W-1:0]    w_head_in;
    logic [W-1:0]    w_hnew;
    logic [W-1:0]    w_scol [MAX_N+1];
    logic [W-1:0]    w_sh [MAX_N+1];
    logic            w_acc;
    logic            w_pop;
    logic            w_push;
    logic            w_last_row;
    logic            w_fin;
    logic [W-1:0]    w_width;
    logic [2*W-1:0]  w_area;

    mera_pkg::t_hgt_ctl w_hctl;
    mera_pkg::t_stk_ctl w_sctl;

    always_comb begin
        if (r_grid == '0) begin
            w_n = W'(1);
        end else if (32'(r_grid) > 32'(MAX_N)) begin
            w_n = W'(MAX_N);
        end else begin
            w_n = W'(r_grid);
        end
    end

    assign w_head = w_hq[MAX_N-1];
    assign w_acc  = s_axis_tvalid && (r_state == S_RUN);

    always_comb begin
        if (s_axis_tdata[0]) begin
            w_hnew = '0;
        end else if (w_head < w_n) begin
            w_hnew = w_head + W'(1);
        end else begin
            w_hnew = w_head;
        end
    end

    assign w_pop = (r_depth != '0) &&
                   ((r_state == S_FLUSH) || ((r_state == S_POP) && (w_sh[0] >= r_cur_h)));
    assign w_push = (r_state == S_POP) && !w_pop && (32'(r_depth) < 32'(MAX_N));

    assign w_width = (r_depth > W'(1)) ? (r_cur_i - w_scol[1] - W'(1)) : r_cur_i;
    assign w_area  = (2*W)'(w_sh[0]) * (2*W)'(w_width);

    assign w_last_row = (r_row == w_n - W'(1));
    assign w_fin = (r_state == S_FLUSH) && (r_depth == '0) && (r_rot == '0) &&
                   !(w_last_row && r_ovalid && !m_axis_tready);

    assign w_hctl.clear = i_cfg_we || (w_fin && w_last_row);
    assign w_hctl.shift = w_acc || ((r_state == S_FLUSH) && (r_rot != '0));
    assign w_head_in    = (r_state == S_RUN) ? w_hnew : w_head;

    assign w_sctl.push = w_push && !i_cfg_we;
    assign w_sctl.pop  = w_pop && !i_cfg_we;

    assign w_scol[MAX_N] = '0;
    assign w_sh[MAX_N]   = '0;

    for (genvar k = 0; k < MAX_N; k++) begin : g_cells
        logic [W-1:0] w_hin;
        logic [W-1:0] w_acol;
        logic [W-1:0] w_ah;

        if (k == 0) begin : g_first
            assign w_hin  = w_head_in;
            assign w_acol = r_cur_i;
            assign w_ah   = r_cur_h;
        end else begin : g_rest
            assign w_hin  = w_hq[k-1];
            assign w_acol = w_scol[k-1];
            assign w_ah   = w_sh[k-1];
        end

        mera_height_cell #(.W(W)) u_hcell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_hctl),
            .i_h     (w_hin),
            .o_h     (w_hq[k])
        );

        mera_stack_cell #(.W(W)) u_scell (
            .i_clk       (i_clk),
            .i_ctl       (w_sctl),
            .i_above_col (w_acol),
            .i_above_h   (w_ah),
            .i_below_col (w_scol[k+1]),
            .i_below_h   (w_sh[k+1]),
            .o_col       (w_scol[k]),
            .o_h         (w_sh[k])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_row    = r_row;
        n_depth  = r_depth;
        n_cur_h  = r_cur_h;
        n_cur_i  = r_cur_i;
        n_rot    = r_rot;
        n_best   = r_best;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata  = r_odata;
        case (r_state)
            S_RUN: begin
                if (w_acc) begin
                    n_cur_h = w_hnew;
                    n_cur_i = r_col;
                    n_col   = (r_col == w_n - W'(1)) ? '0 : r_col + W'(1);
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (w_pop) begin
                    n_depth = r_depth - W'(1);
                    if (w_area > r_best) begin
                        n_best = w_area;
                    end
                end else begin
                    if (w_push) begin
                        n_depth = r_depth + W'(1);
                    end
                    if (r_cur_i == w_n - W'(1)) begin
                        n_cur_h = '0;
                        n_cur_i = w_n;
                        n_rot   = W'(MAX_N) - w_n;
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_FLUSH: begin
                if (w_pop) begin
                    n_depth = r_depth - W'(1);
                    if (w_area > r_best) begin
                        n_best = w_area;
                    end
                end
                if (r_rot != '0) begin
                    n_rot = r_rot - W'(1);
                end
                if (w_fin) begin
                    n_state = S_RUN;
                    if (w_last_row) begin
                        n_row    = '0;
                        n_best   = '0;
                        n_ovalid = 1'b1;
                        n_odata  = AW'(r_best);
                    end else begin
                        n_row = r_row + W'(1);
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_RUN;
            r_grid   <= GW'(mera_pkg::GRID_RESET);
            r_col    <= '0;
            r_row    <= '0;
            r_depth  <= '0;
            r_rot    <= '0;
            r_best   <= '0;
            r_ovalid <= 1'b0;
        end else if (i_cfg_we) begin
            r_state  <= S_RUN;
            r_grid   <= i_cfg_wdata;
            r_col    <= '0;
            r_row    <= '0;
            r_depth  <= '0;
            r_rot    <= '0;
            r_best   <= '0;
            r_ovalid <= n_ovalid;
        end else begin
            r_state  <= n_state;
            r_col    <= n_col;
            r_row    <= n_row;
            r_depth  <= n_depth;
            r_rot    <= n_rot;
            r_best   <= n_best;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_h <= n_cur_h;
        r_cur_i <= n_cur_i;
        r_odata <= n_odata;
    end

    assign s_axis_tready = (r_state == S_RUN);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OW'(r_odata);

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_depth <= r_col))
        else $error("stack deeper than the columns of the row so far");

    a_accept_to_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_cfg_we) |=> (r_state == S_POP))
        else $error("accepted cell did not enter the stack step");

    a_flush_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FLUSH) && $past(r_state == S_FLUSH)) |-> (r_depth <= $past(r_depth)))
        else $error("stack grew during the row-end flush");

    a_counts_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> ((r_row < w_n) && (r_col < w_n)))
        else $error("row or column count beyond the grid size");

endmodule

FILE: design/mera_height_cell.sv
module mera_height_cell #(
    parameter int W = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mera_pkg::t_hgt_ctl i_ctl,
    input  logic [W-1:0]      i_h,
    output logic [W-1:0]      o_h
);

    logic [W-1:0] r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= '0;
        end else if (i_ctl.clear) begin
            r_h <= '0;
        end else if (i_ctl.shift) begin
            r_h <= i_h;
        end
    end

    assign o_h = r_h;

endmodule

FILE: design/mera_stack_cell.sv
module mera_stack_cell #(
    parameter int W = 7
) (
    input  logic               i_clk,
    input  mera_pkg::t_stk_ctl i_ctl,
    input  logic [W-1:0]       i_above_col,
    input  logic [W-1:0]       i_above_h,
    input  logic [W-1:0]       i_below_col,
    input  logic [W-1:0]       i_below_h,
    output logic [W-1:0]       o_col,
    output logic [W-1:0]       o_h
);

    logic [W-1:0] r_col;
    logic [W-1:0] r_h;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_col <= i_above_col;
            r_h   <= i_above_h;
        end else if (i_ctl.pop) begin
            r_col <= i_below_col;
            r_h   <= i_below_h;
        end
    end

    assign o_col = r_col;
    assign o_h   = r_h;

endmodule

FILE: verif/max_empty_rectangle_area_checker.sv
`timescale 1ns / 1ps

module max_empty_rectangle_area_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mera_pkg::GRID_W-1:0]      i_cfg_wdata,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [mera_pkg::IN_TDATA_W-1:0]  i_in_data,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [mera_pkg::OUT_TDATA_W-1:0] i_out_data,
    output int                               o_pending,
    output int                               o_fail_count,
    output int                               o_checked
);

    localparam int SIDE_MAX = mera_pkg::MAX_N_DEF;

    logic [mera_pkg::GRID_W-1:0] grid_reg;
    int                          col_height [SIDE_MAX];
    int                          col_idx;
    int                          row_idx;
    int                          best_area;
    int                          fails   = 0;
    int                          checked = 0;
    logic [mera_pkg::AREA_W-1:0] expected_areas [$];

    function automatic int grid_side(input logic [mera_pkg::GRID_W-1:0] g);
        if (g == '0) begin
            return 1;
        end
        if (int'(g) > SIDE_MAX) begin
            return SIDE_MAX;
        end
        return int'(g);
    endfunction

    function automatic void clear_grid();
        for (int c = 0; c < SIDE_MAX; c++) begin
            col_height[c] = 0;
        end
        col_idx   = 0;
        row_idx   = 0;
        best_area = 0;
    endfunction

    // Largest rectangle under the column heights, found with a stack of
    // column indexes whose heights rise from bottom to top.
    function automatic void scan_row(input int n);
        int open_cols [SIDE_MAX + 1];
        int sp;
        int h;
        int bar;
        int span;
        sp = 0;
        for (int i = 0; i <= n; i++) begin
            h = (i < n) ? col_height[i] : 0;
            while (sp > 0 && col_height[open_cols[sp - 1]] >= h) begin
                bar = col_height[open_cols[sp - 1]];
                sp--;
                span = (sp > 0) ? i - open_cols[sp - 1] - 1 : i;
                if (bar * span > best_area) begin
                    best_area = bar * span;
                end
            end
            if (i < n) begin
                open_cols[sp] = i;
                sp++;
            end
        end
    endfunction

    function automatic void take_cell(input logic blocked);
        int n;
        n = grid_side(grid_reg);
        if (blocked) begin
            col_height[col_idx] = 0;
        end else if (col_height[col_idx] < n) begin
            col_height[col_idx]++;
        end
        col_idx++;
        if (col_idx >= n) begin
            col_idx = 0;
            scan_row(n);
            row_idx++;
            if (row_idx >= n) begin
                expected_areas.push_back(best_area[mera_pkg::AREA_W-1:0]);
                clear_grid();
            end
        end
    endfunction

    always @(posedge i_clk) begin : watch
        logic [mera_pkg::AREA_W-1:0] want;
        if (!i_rst_n) begin
            grid_reg = mera_pkg::GRID_W'(mera_pkg::GRID_RESET);
            clear_grid();
            expected_areas.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_areas.size() == 0) begin
                    $display("%0t: unexpected max_area transfer %0d with nothing expected",
                             $time, i_out_data);
                    fails++;
                end else begin
                    want = expected_areas.pop_front();
                    checked++;
                    if (i_out_data !==
                        {{(mera_pkg::OUT_TDATA_W - mera_pkg::AREA_W){1'b0}}, want}) begin
                        $display("%0t: max_area mismatch, expected %0d, actual %0d",
                                 $time, want, i_out_data);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) begin
                grid_reg = i_cfg_wdata;
                clear_grid();
            end
            if (i_in_valid && i_in_ready) begin
                take_cell(i_in_data[0]);
            end
        end
        o_pending    <= expected_areas.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

FILE: verif/tb_max_empty_rectangle_area_unit.sv
`timescale 1ns / 1ps

module tb_max_empty_rectangle_area_unit;

    localparam int SETTLE = 4 * mera_pkg::MAX_N_DEF;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_we      = 1'b0;
    logic [mera_pkg::GRID_W-1:0]      i_cfg_wdata   = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [mera_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [mera_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int cells_sent   = 0;
    int sizes_written = 0;
    int pending;
    int fail_count;
    int checked;

    max_empty_rectangle_area_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    max_empty_rectangle_area_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_checked    (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Valid stays high from one transfer to the next unless a gap is rolled.
    task automatic send_cell(input logic blocked);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(mera_pkg::IN_TDATA_W - 1){1'b0}}, blocked};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        cells_sent++;
    endtask

    task automatic send_cells(input logic [63:0] pattern, input int count);
        for (int k = 0; k < count; k++) begin
            send_cell(pattern[k]);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_grid(input logic [mera_pkg::GRID_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        sizes_written++;
    endtask

    function automatic int side_for(input logic [mera_pkg::GRID_W-1:0] value);
        if (value == '0) begin
            return 1;
        end
        return (int'(value) > mera_pkg::MAX_N_DEF) ? mera_pkg::MAX_N_DEF : int'(value);
    endfunction

    function automatic int pick_density();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            return 0;
        end
        if (roll == 1) begin
            return 100;
        end
        return $urandom_range(5, 60);
    endfunction

    task automatic send_grid(input logic [mera_pkg::GRID_W-1:0] value, input int blocked_pct);
        int n;
        n = side_for(value);
        repeat (n * n) send_cell($urandom_range(0, 99) < blocked_pct);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int budget);
        int                          first_cell;
        int                          roll;
        int                          n;
        logic [mera_pkg::GRID_W-1:0] value;
        drain();
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        first_cell   = cells_sent;
        while (cells_sent - first_cell < budget) begin
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
                value = '0;
            end else if (roll < 15) begin
                value = mera_pkg::GRID_W'($urandom_range(1, 8));
            end else begin
                value = mera_pkg::GRID_W'($urandom_range(9, 16));
            end
            write_grid(value);
            repeat ($urandom_range(1, 3)) send_grid(value, pick_density());
            n = side_for(value);
            if (n > 1 && $urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, n * n - 1)) send_cell(1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One full row at the size left by reset; the next size write drops it.
        send_cells(64'hF00F_0FF0_00FF_0001, 64);

        write_grid('0);
        send_cells(64'b10, 2);
        write_grid(mera_pkg::GRID_W'(1));
        send_cells(64'b01, 2);
        write_grid(mera_pkg::GRID_W'(2));
        send_cells(64'h0, 4);
        send_cells(64'hF, 4);
        send_cells(64'b1001, 4);
        write_grid(mera_pkg::GRID_W'(3));
        send_cells(64'h0, 4);
        write_grid(mera_pkg::GRID_W'(3));
        send_cells(64'b000_010_000, 9);

        write_grid('1);
        send_cells(64'h0FF0_F00F_FF00_00FF, 64);

        run_phase(0, 0, 200);
        run_phase(78, 0, 200);
        run_phase(0, 78, 200);
        run_phase(31, 31, 200);

        drain();
        $display("Sent %0d cells under %0d grid size writes, sizes 0 to 127 among them.",
                 cells_sent, sizes_written);
        $display("Checked %0d areas across free-flowing, idle-sender and stalled-receiver runs.",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_max_empty_rectangle_area_unit passed");
        end else begin
            $display("tb_max_empty_rectangle_area_unit failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_max_empty_rectangle_area_unit failed");
        $finish;
    end

endmodule

FILE: sim.f
design/mera_pkg.sv
design/mera_height_cell.sv
design/mera_stack_cell.sv
design/max_empty_rectangle_area_unit.sv
verif/max_empty_rectangle_area_checker.sv
verif/tb_max_empty_rectangle_area_unit.sv
